FILE: hw/rtl/primitive_to_triangle_list_assert.svh
// Assertion macros shared by the primitive assembly RTL.
`ifndef PRIMITIVE_TO_TRIANGLE_LIST_ASSERT_SVH
`define PRIMITIVE_TO_TRIANGLE_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ptl_pkg.sv
// Types, codes and helper functions of the primitive assembly block.
package ptl_pkg;

	// register indexes
	localparam logic [2:0] REG_PRIM_MODE  = 3'd0;
	localparam logic [2:0] REG_MOD_RED    = 3'd1;
	localparam logic [2:0] REG_MOD_GREEN  = 3'd2;
	localparam logic [2:0] REG_MOD_BLUE   = 3'd3;
	localparam logic [2:0] REG_MOD_ALPHA  = 3'd4;
	localparam logic [2:0] REG_CA_ENABLE  = 3'd5;
	localparam logic [2:0] REG_CONST_ALPHA = 3'd6;

	// primitive modes
	localparam logic [1:0] MODE_LIST  = 2'd0;
	localparam logic [1:0] MODE_QUAD  = 2'd1;
	localparam logic [1:0] MODE_STRIP = 2'd2;
	localparam logic [1:0] MODE_FAN   = 2'd3;

	// back-end actions
	localparam logic [2:0] ACT_STORE = 3'd0;
	localparam logic [2:0] ACT_PASS  = 3'd1;
	localparam logic [2:0] ACT_QUAD  = 3'd2;
	localparam logic [2:0] ACT_STRIP = 3'd3;
	localparam logic [2:0] ACT_FAN   = 3'd4;

	// vertex sources for one emitted result
	localparam logic [1:0] SRC_S0 = 2'd0;
	localparam logic [1:0] SRC_S1 = 2'd1;
	localparam logic [1:0] SRC_S2 = 2'd2;
	localparam logic [1:0] SRC_V  = 2'd3;

	localparam int NUM_SLOTS = 3;

	// command queue
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// reciprocals: x/255 for 16-bit x, y/255 for y below 2^24
	localparam logic [15:0] RECIP_255_16 = 16'd32897;
	localparam logic [24:0] RECIP_255_24 = 25'd16843010;
	localparam logic [7:0]  ROUND_8      = 8'd127;
	localparam logic [14:0] ROUND_16     = 15'd32512;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] mod_red;
		logic [7:0] mod_green;
		logic [7:0] mod_blue;
		logic [7:0] mod_alpha;
		logic       ca_en;
		logic [7:0] const_alpha;
	} ptl_cfg_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
	} ptl_vtx_t;

	typedef struct packed {
		logic [2:0] act;
		logic       par;
		logic [1:0] idx;
	} ptl_ctl_t;

	typedef struct packed {
		ptl_ctl_t ctl;
		ptl_vtx_t vtx;
	} ptl_cmd_t;

	typedef struct packed {
		logic [1:0] src;
		logic       last;
	} ptl_pick_t;

	// Which vertex goes out at a given step of an action.
	function automatic ptl_pick_t ptl_pick(input logic [2:0] act, input logic par,
			input logic [2:0] step);
		ptl_pick_t p;
		p.src  = SRC_V;
		p.last = 1'b1;
		case (act)
			ACT_QUAD: begin
				p.last = (step == 3'd5);
				case (step)
					3'd0: p.src = SRC_S0;
					3'd1: p.src = SRC_S1;
					3'd2: p.src = SRC_S2;
					3'd3: p.src = SRC_S0;
					3'd4: p.src = SRC_S2;
					default: p.src = SRC_V;
				endcase
			end
			ACT_STRIP: begin
				p.last = (step == 3'd2);
				case (step)
					3'd0: p.src = par ? SRC_S1 : SRC_S0;
					3'd1: p.src = par ? SRC_S0 : SRC_S1;
					default: p.src = SRC_V;
				endcase
			end
			ACT_FAN: begin
				p.last = (step == 3'd2);
				case (step)
					3'd0: p.src = SRC_S0;
					3'd1: p.src = SRC_S1;
					default: p.src = SRC_V;
				endcase
			end
			default: begin
				p.src  = SRC_V;
				p.last = 1'b1;
			end
		endcase
		return p;
	endfunction

endpackage

FILE: hw/rtl/primitive_to_triangle_list.sv
// Top level of the primitive assembly block: configuration registers and block wiring.
//
// Usage: one vertex of a draw is requested per in_valid/in_ready handshake;
// start_of_draw marks the first vertex of a draw. Results leave on the
// out_valid/out_ready channel as vertices of an independent triangle list,
// run_last flagging the last vertex produced by an input request.
// Configuration goes through cfg_we/cfg_index/cfg_data, one register per
// cycle; the user must write it only while the block is idle, which the
// block itself does not enforce; unknown indexes are ignored.
// The first vertex a request emits passes the four-stage colour pipeline,
// the queue and the output register on its way to the output.
// Throughput: the front takes one request per cycle while in_ready is high.
// The back sends one result per cycle while out_ready allows; a list request
// gives one result, a strip or fan request three once primed, the fourth
// vertex of a quad six, and a held vertex none; the output sequencer paces it.
// Reset clears the assembly count, strip parity, queue and output valid and
// loads register defaults; vertex slots are undefined until stored.
// A stalled receiver holds the output register; the two-entry command queue
// then fills and in_ready drops, stalling the front pipeline in place.
module primitive_to_triangle_list
	import ptl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_pos_x,
	input  logic [31:0] in_pos_y,
	input  logic [31:0] in_pos_z,
	input  logic [31:0] in_tex_u,
	input  logic [31:0] in_tex_v,
	input  logic [31:0] in_color,
	input  logic        start_of_draw,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_pos_x,
	output logic [31:0] out_pos_y,
	output logic [31:0] out_pos_z,
	output logic [31:0] out_tex_u,
	output logic [31:0] out_tex_v,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic        run_last
);

	ptl_cfg_t cfg_q;

	// front to queue
	logic     fq_valid;
	logic     fq_ready;
	ptl_cmd_t fq_data;
	// queue to back
	logic     bq_valid;
	logic     bq_pop;
	ptl_cmd_t bq_data;

	// register file, values masked to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_LIST;
			cfg_q.mod_red     <= 8'hff;
			cfg_q.mod_green   <= 8'hff;
			cfg_q.mod_blue    <= 8'hff;
			cfg_q.mod_alpha   <= 8'hff;
			cfg_q.ca_en       <= 1'b0;
			cfg_q.const_alpha <= 8'hff;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRIM_MODE:   cfg_q.mode        <= cfg_data[1:0];
				REG_MOD_RED:     cfg_q.mod_red     <= cfg_data;
				REG_MOD_GREEN:   cfg_q.mod_green   <= cfg_data;
				REG_MOD_BLUE:    cfg_q.mod_blue    <= cfg_data;
				REG_MOD_ALPHA:   cfg_q.mod_alpha   <= cfg_data;
				REG_CA_ENABLE:   cfg_q.ca_en       <= cfg_data[0];
				REG_CONST_ALPHA: cfg_q.const_alpha <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify and modulate colour
	ptl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_pos_x      (in_pos_x),
		.in_pos_y      (in_pos_y),
		.in_pos_z      (in_pos_z),
		.in_tex_u      (in_tex_u),
		.in_tex_v      (in_tex_v),
		.in_color      (in_color),
		.start_of_draw (start_of_draw),
		.q_valid       (fq_valid),
		.q_ready       (fq_ready),
		.q_data        (fq_data)
	);

	// decouples the per-request front from the multi-result back
	ptl_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (bq_valid),
		.pop        (bq_pop),
		.pop_data   (bq_data)
	);

	// slot storage and result sequencing
	ptl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (bq_valid),
		.q_pop     (bq_pop),
		.q_data    (bq_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pos_x (out_pos_x),
		.out_pos_y (out_pos_y),
		.out_pos_z (out_pos_z),
		.out_tex_u (out_tex_u),
		.out_tex_v (out_tex_v),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_alpha (out_alpha),
		.run_last  (run_last)
	);

endmodule

FILE: hw/rtl/ptl_front.sv
// Front end: vertex intake, assembly classification and colour modulation pipeline.
module ptl_front
	import ptl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ptl_cfg_t    cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_pos_x,
	input  logic [31:0] in_pos_y,
	input  logic [31:0] in_pos_z,
	input  logic [31:0] in_tex_u,
	input  logic [31:0] in_tex_v,
	input  logic [31:0] in_color,
	input  logic        start_of_draw,
	output logic        q_valid,
	input  logic        q_ready,
	output ptl_cmd_t    q_data
);
`include "primitive_to_triangle_list_assert.svh"

	logic        adv;
	logic        take;
	logic [1:0]  cnt_q;
	logic        par_q;
	logic [1:0]  cnt_cur;
	logic        par_cur;
	logic [1:0]  cnt_nxt;
	logic        par_nxt;
	ptl_ctl_t    ctl_nxt;

	logic        v_s1, v_s2, v_s3, v_s4;
	ptl_ctl_t    ctl_s1, ctl_s2, ctl_s3;
	logic [159:0] pt_s1, pt_s2, pt_s3;
	logic [15:0] prod_s1 [4];
	logic [30:0] mul_s2 [4];
	logic [23:0] ya_s2;
	logic [7:0]  chan_s3 [4];
	logic [16:0] hi_s3;
	ptl_cmd_t    cmd_s4;

	logic [7:0]  src_ch [4];
	logic [7:0]  mod_ch [4];
	logic [23:0] ya_rnd;
	logic [48:0] hi_prod;
	logic [30:0] ca_prod;

	assign adv      = !v_s4 || q_ready;
	assign in_ready = adv;
	assign take     = in_valid && adv;
	assign q_valid  = v_s4;
	assign q_data   = cmd_s4;

	assign src_ch[0] = in_color[31:24];
	assign src_ch[1] = in_color[23:16];
	assign src_ch[2] = in_color[15:8];
	assign src_ch[3] = in_color[7:0];
	assign mod_ch[0] = cfg.mod_red;
	assign mod_ch[1] = cfg.mod_green;
	assign mod_ch[2] = cfg.mod_blue;
	assign mod_ch[3] = cfg.mod_alpha;

	// classification against the assembly state, start of draw clears first
	always_comb begin
		cnt_cur = start_of_draw ? 2'd0 : cnt_q;
		par_cur = start_of_draw ? 1'b0 : par_q;
		cnt_nxt = cnt_cur;
		par_nxt = par_cur;
		ctl_nxt.act = ACT_PASS;
		ctl_nxt.par = par_cur;
		ctl_nxt.idx = cnt_cur;
		case (cfg.mode)
			MODE_LIST: ctl_nxt.act = ACT_PASS;
			MODE_QUAD: begin
				if (cnt_cur < 2'd3) begin
					ctl_nxt.act = ACT_STORE;
					cnt_nxt = cnt_cur + 2'd1;
				end else begin
					ctl_nxt.act = ACT_QUAD;
					cnt_nxt = 2'd0;
				end
			end
			MODE_STRIP: begin
				if (cnt_cur < 2'd2) begin
					ctl_nxt.act = ACT_STORE;
					cnt_nxt = cnt_cur + 2'd1;
				end else begin
					ctl_nxt.act = ACT_STRIP;
					cnt_nxt = 2'd2;
					par_nxt = !par_cur;
				end
			end
			default: begin
				if (cnt_cur < 2'd2) begin
					ctl_nxt.act = ACT_STORE;
					cnt_nxt = cnt_cur + 2'd1;
				end else begin
					ctl_nxt.act = ACT_FAN;
					cnt_nxt = 2'd2;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			par_q <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			if (take) begin
				cnt_q <= cnt_nxt;
				par_q <= par_nxt;
			end
			if (adv) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	assign ya_rnd  = ya_s2 + {9'd0, ROUND_16};
	assign hi_prod = {25'd0, ya_rnd} * {24'd0, RECIP_255_24};
	assign ca_prod = {14'd0, hi_s3} * {15'd0, RECIP_255_16};

	// s1 products, s2 reciprocal multiply, s3 quotients, s4 second alpha divide
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_nxt;
			pt_s1  <= {in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v};
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= {8'd0, src_ch[i]} * {8'd0, mod_ch[i]};
			end

			ctl_s2 <= ctl_s1;
			pt_s2  <= pt_s1;
			for (int i = 0; i < 4; i++) begin
				mul_s2[i] <= {14'd0, {1'b0, prod_s1[i]} + {9'd0, ROUND_8}} *
					{15'd0, RECIP_255_16};
			end
			ya_s2 <= {8'd0, prod_s1[3]} * {16'd0, cfg.const_alpha};

			ctl_s3 <= ctl_s2;
			pt_s3  <= pt_s2;
			for (int i = 0; i < 4; i++) begin
				chan_s3[i] <= mul_s2[i][30:23];
			end
			hi_s3 <= hi_prod[48:32];

			cmd_s4.ctl       <= ctl_s3;
			cmd_s4.vtx.pos_x <= pt_s3[159:128];
			cmd_s4.vtx.pos_y <= pt_s3[127:96];
			cmd_s4.vtx.pos_z <= pt_s3[95:64];
			cmd_s4.vtx.tex_u <= pt_s3[63:32];
			cmd_s4.vtx.tex_v <= pt_s3[31:0];
			cmd_s4.vtx.red   <= chan_s3[0];
			cmd_s4.vtx.green <= chan_s3[1];
			cmd_s4.vtx.blue  <= chan_s3[2];
			cmd_s4.vtx.alpha <= cfg.ca_en ? ca_prod[30:23] : chan_s3[3];
		end
	end

	`PTL_ASSERT_NXT(a_front_hold, clk, arst_n, v_s4 && !q_ready, v_s4 && $stable(cmd_s4), "front: stalled command changed")

endmodule

FILE: hw/rtl/ptl_fifo.sv
// Short command queue between the front and back ends.
module ptl_fifo
	import ptl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  ptl_cmd_t push_data,
	output logic     pop_valid,
	input  logic     pop,
	output ptl_cmd_t pop_data
);
`include "primitive_to_triangle_list_assert.svh"

	ptl_cmd_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != Q_CW'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [Q_AW-1:0] bump(input logic [Q_AW-1:0] p);
		return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= bump(wr_q);
			if (do_pop) rd_q <= bump(rd_q);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	`PTL_ASSERT_IMP(a_fifo_pop, clk, arst_n, pop, count_q != '0, "fifo: pop from empty queue")

endmodule

FILE: hw/rtl/ptl_back.sv
// Back end: vertex slots and the sequencer that emits triangle-list vertices.
module ptl_back
	import ptl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  ptl_cmd_t    q_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_pos_x,
	output logic [31:0] out_pos_y,
	output logic [31:0] out_pos_z,
	output logic [31:0] out_tex_u,
	output logic [31:0] out_tex_v,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic        run_last
);
`include "primitive_to_triangle_list_assert.svh"

	ptl_vtx_t  slot_q [NUM_SLOTS];
	logic [2:0] step_q;
	logic       out_valid_q;
	ptl_vtx_t   out_q;
	logic       last_q;
	ptl_pick_t  pk;
	ptl_vtx_t   src_vtx;
	logic       is_store;
	logic       store_go;
	logic       ld;
	logic       done;

	assign pk       = ptl_pick(q_data.ctl.act, q_data.ctl.par, step_q);
	assign is_store = (q_data.ctl.act == ACT_STORE);
	assign store_go = q_valid && is_store;
	assign ld       = q_valid && !is_store && (!out_valid_q || out_ready);
	assign done     = ld && pk.last;
	assign q_pop    = store_go || done;

	always_comb begin
		case (pk.src)
			SRC_S0: src_vtx = slot_q[0];
			SRC_S1: src_vtx = slot_q[1];
			SRC_S2: src_vtx = slot_q[2];
			default: src_vtx = q_data.vtx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (done) step_q <= 3'd0;
			else if (ld) step_q <= step_q + 3'd1;
			if (ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_q  <= src_vtx;
			last_q <= pk.last;
		end
		if (store_go) slot_q[q_data.ctl.idx] <= q_data.vtx;
		if (done && q_data.ctl.act == ACT_STRIP) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= q_data.vtx;
		end
		if (done && q_data.ctl.act == ACT_FAN) slot_q[1] <= q_data.vtx;
	end

	assign out_valid = out_valid_q;
	assign out_pos_x = out_q.pos_x;
	assign out_pos_y = out_q.pos_y;
	assign out_pos_z = out_q.pos_z;
	assign out_tex_u = out_q.tex_u;
	assign out_tex_v = out_q.tex_v;
	assign out_red   = out_q.red;
	assign out_green = out_q.green;
	assign out_blue  = out_q.blue;
	assign out_alpha = out_q.alpha;
	assign run_last  = last_q;

	`PTL_ASSERT_NXT(a_back_wrap, clk, arst_n, done, step_q == 3'd0, "back: step did not wrap after last vertex")
	`PTL_ASSERT_IMP(a_back_head, clk, arst_n, step_q != 3'd0, q_valid && !is_store, "back: command left mid-sequence")

endmodule

FILE: sim/primitive_to_triangle_list_tb.sv
// Self-checking testbench of the primitive assembly block, with a cycle-free triangle list predictor.
module primitive_to_triangle_list_tb;
	import ptl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// index that no register answers to
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// wait after the last expected vertex, with slack for stores still in the front pipeline and queue
	localparam int DRAIN_CYCLES   = 24;
	// cycles with no handshake on either side before the run is called hung
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;

	// one vertex request as the sender sees it
	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
		logic [31:0] color;
		logic        sod;
	} draw_vertex_t;

	// one vertex of the output triangle list
	typedef struct packed {
		ptl_vtx_t vtx;
		logic     last;
	} list_vertex_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] in_pos_x = '0;
	logic [31:0] in_pos_y = '0;
	logic [31:0] in_pos_z = '0;
	logic [31:0] in_tex_u = '0;
	logic [31:0] in_tex_v = '0;
	logic [31:0] in_color = '0;
	logic        start_of_draw = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] out_pos_x;
	logic [31:0] out_pos_y;
	logic [31:0] out_pos_z;
	logic [31:0] out_tex_u;
	logic [31:0] out_tex_v;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [7:0]  out_alpha;
	logic        run_last;

	// idling knobs, percent of cycles
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	// receiver hold-off, counted down by the receiver process
	int hold_len     = 0;
	int errors       = 0;
	int quiet_cycles = 0;

	// predictor copy of the registers
	logic [1:0] cur_mode;
	logic [7:0] cur_mod_red, cur_mod_green, cur_mod_blue, cur_mod_alpha;
	logic       cur_ca_en;
	logic [7:0] cur_const_alpha;

	// predictor copy of the assembly state
	ptl_vtx_t   held_slots [NUM_SLOTS];
	logic [1:0] held_count;
	logic       strip_odd;

	list_vertex_t expected_vertices [$];

	primitive_to_triangle_list i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_pos_x      (in_pos_x),
		.in_pos_y      (in_pos_y),
		.in_pos_z      (in_pos_z),
		.in_tex_u      (in_tex_u),
		.in_tex_v      (in_tex_v),
		.in_color      (in_color),
		.start_of_draw (start_of_draw),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_pos_x     (out_pos_x),
		.out_pos_y     (out_pos_y),
		.out_pos_z     (out_pos_z),
		.out_tex_u     (out_tex_u),
		.out_tex_v     (out_tex_v),
		.out_red       (out_red),
		.out_green     (out_green),
		.out_blue      (out_blue),
		.out_alpha     (out_alpha),
		.run_last      (run_last)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// unorm8 * unorm8, rounded to nearest
	function automatic logic [7:0] scale_channel(input logic [7:0] s, input logic [7:0] m);
		int unsigned su, mu;
		su = s;
		mu = m;
		return 8'((su * mu + 127) / 255);
	endfunction

	// colour modulation with the registers in force when the vertex is taken
	function automatic ptl_vtx_t shade_vertex(input draw_vertex_t v);
		ptl_vtx_t c;
		int unsigned sa, ma, ca;
		c.pos_x = v.pos_x;
		c.pos_y = v.pos_y;
		c.pos_z = v.pos_z;
		c.tex_u = v.tex_u;
		c.tex_v = v.tex_v;
		c.red   = scale_channel(v.color[31:24], cur_mod_red);
		c.green = scale_channel(v.color[23:16], cur_mod_green);
		c.blue  = scale_channel(v.color[15:8], cur_mod_blue);
		if (cur_ca_en) begin
			// alpha * mod * const, one rounding over 255*255
			sa = v.color[7:0];
			ma = cur_mod_alpha;
			ca = cur_const_alpha;
			c.alpha = 8'((sa * ma * ca + 32512) / 65025);
		end else begin
			c.alpha = scale_channel(v.color[7:0], cur_mod_alpha);
		end
		return c;
	endfunction

	function automatic void queue_vertex(input ptl_vtx_t v, input logic last);
		list_vertex_t e;
		e.vtx  = v;
		e.last = last;
		expected_vertices.insert(expected_vertices.size(), e);
	endfunction

	// Primitive assembly of one accepted request into triangle-list vertices.
	function automatic void assemble_vertex(input draw_vertex_t v);
		ptl_vtx_t c;
		c = shade_vertex(v);
		// start of draw clears count and parity before the vertex is taken
		if (v.sod) begin
			held_count = 2'd0;
			strip_odd  = 1'b0;
		end
		case (cur_mode)
			MODE_LIST: begin
				// count and slots untouched
				queue_vertex(c, 1'b1);
			end
			MODE_QUAD: begin
				if (held_count < 2'd3) begin
					held_slots[held_count] = c;
					held_count = held_count + 2'd1;
				end else begin
					queue_vertex(held_slots[0], 1'b0);
					queue_vertex(held_slots[1], 1'b0);
					queue_vertex(held_slots[2], 1'b0);
					queue_vertex(held_slots[0], 1'b0);
					queue_vertex(held_slots[2], 1'b0);
					queue_vertex(c, 1'b1);
					held_count = 2'd0;
				end
			end
			MODE_STRIP: begin
				// a count of 3 left over from quad mode acts as 2
				if (held_count < 2'd2) begin
					held_slots[held_count] = c;
					held_count = held_count + 2'd1;
				end else begin
					if (!strip_odd) begin
						queue_vertex(held_slots[0], 1'b0);
						queue_vertex(held_slots[1], 1'b0);
					end else begin
						queue_vertex(held_slots[1], 1'b0);
						queue_vertex(held_slots[0], 1'b0);
					end
					queue_vertex(c, 1'b1);
					held_slots[0] = held_slots[1];
					held_slots[1] = c;
					strip_odd  = ~strip_odd;
					held_count = 2'd2;
				end
			end
			default: begin
				// fan: slot 0 stays the origin
				if (held_count < 2'd2) begin
					held_slots[held_count] = c;
					held_count = held_count + 2'd1;
				end else begin
					queue_vertex(held_slots[0], 1'b0);
					queue_vertex(held_slots[1], 1'b0);
					queue_vertex(c, 1'b1);
					held_slots[1] = c;
					held_count = 2'd2;
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// Register write; only called while the block is idle.
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PRIM_MODE:   cur_mode        = data[1:0];
			REG_MOD_RED:     cur_mod_red     = data;
			REG_MOD_GREEN:   cur_mod_green   = data;
			REG_MOD_BLUE:    cur_mod_blue    = data;
			REG_MOD_ALPHA:   cur_mod_alpha   = data;
			REG_CA_ENABLE:   cur_ca_en       = data[0];
			REG_CONST_ALPHA: cur_const_alpha = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offers one vertex request and returns at the edge that takes it.
	task automatic send_vertex(input draw_vertex_t v);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid      <= 1'b1;
		in_pos_x      <= v.pos_x;
		in_pos_y      <= v.pos_y;
		in_pos_z      <= v.pos_z;
		in_tex_u      <= v.tex_u;
		in_tex_v      <= v.tex_v;
		in_color      <= v.color;
		start_of_draw <= v.sod;
		do @(posedge clk); while (!in_ready);
		assemble_vertex(v);
	endtask

	// Sender goes quiet until every expected vertex is out and the pipe has emptied.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_vertices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic draw_vertex_t make_vertex(input logic [31:0] color, input logic sod);
		draw_vertex_t v;
		v.pos_x = $urandom;
		v.pos_y = $urandom;
		v.pos_z = $urandom;
		v.tex_u = $urandom;
		v.tex_v = $urandom;
		v.color = color;
		v.sod   = sod;
		return v;
	endfunction

	function automatic draw_vertex_t rand_vertex(input logic sod);
		logic [31:0] color;
		case ($urandom_range(4))
			0: color = 32'h0000_0000;
			1: color = 32'hFFFF_FFFF;
			default: color = $urandom;
		endcase
		return make_vertex(color, sod);
	endfunction

	// unorm8 factor, extremes weighted up
	function automatic logic [7:0] pick_factor();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	// Reset defaults: list mode, unity modulation, field extremes pass through.
	task automatic test_list_defaults();
		draw_vertex_t v;
		v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1};
		send_vertex(v);
		v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0};
		send_vertex(v);
		wait_drained();
	endtask

	// Quad list: two triangles per four vertices, an incomplete quad is dropped.
	task automatic test_quad_list();
		write_reg(REG_PRIM_MODE, {6'b0, MODE_QUAD});
		write_reg(REG_MOD_RED, 8'd0);
		write_reg(REG_MOD_GREEN, 8'd128);
		write_reg(REG_MOD_BLUE, 8'd1);
		write_reg(REG_MOD_ALPHA, 8'd254);
		send_vertex(make_vertex(32'hFFFF_FFFF, 1'b1));
		send_vertex(make_vertex(32'h80FF_017F, 1'b0));
		send_vertex(make_vertex(32'h0102_0304, 1'b0));
		send_vertex(make_vertex(32'hFE7F_80FF, 1'b0));
		// two vertices, then a new draw throws them away
		send_vertex(make_vertex($urandom, 1'b1));
		send_vertex(make_vertex($urandom, 1'b0));
		send_vertex(make_vertex($urandom, 1'b1));
		wait_drained();
	endtask

	// Strip: winding flips every triangle; the sender stops mid-draw until drained.
	task automatic test_strip_winding();
		write_reg(REG_PRIM_MODE, {6'b0, MODE_STRIP});
		write_reg(REG_MOD_RED, 8'd255);
		write_reg(REG_MOD_GREEN, 8'd0);
		send_vertex(rand_vertex(1'b1));
		send_vertex(rand_vertex(1'b0));
		send_vertex(rand_vertex(1'b0));
		send_vertex(rand_vertex(1'b0));
		// held vertices and parity must survive an idle gap
		wait_drained();
		send_vertex(rand_vertex(1'b0));
		wait_drained();
	endtask

	// Fan: the first vertex of the draw stays the origin.
	task automatic test_fan_origin();
		write_reg(REG_PRIM_MODE, {6'b0, MODE_FAN});
		send_vertex(rand_vertex(1'b1));
		send_vertex(rand_vertex(1'b0));
		send_vertex(rand_vertex(1'b0));
		send_vertex(rand_vertex(1'b0));
		wait_drained();
	endtask

	// Mode change inside a draw: the new mode works on the held count and slots.
	task automatic test_mode_switch();
		write_reg(REG_PRIM_MODE, {6'b0, MODE_QUAD});
		send_vertex(rand_vertex(1'b1));
		send_vertex(rand_vertex(1'b0));
		send_vertex(rand_vertex(1'b0));
		wait_drained();
		// three held: strip treats the count as two
		write_reg(REG_PRIM_MODE, {6'b0, MODE_STRIP});
		send_vertex(rand_vertex(1'b0));
		wait_drained();
		write_reg(REG_PRIM_MODE, {6'b0, MODE_FAN});
		send_vertex(rand_vertex(1'b0));
		wait_drained();
		// list passes through and leaves the held state alone
		write_reg(REG_PRIM_MODE, {6'b0, MODE_LIST});
		send_vertex(rand_vertex(1'b0));
		wait_drained();
	endtask

	// Constant alpha, data masked to register width, unknown index ignored.
	task automatic test_const_alpha_and_masking();
		write_reg(REG_PRIM_MODE, 8'hFC);
		write_reg(REG_MOD_ALPHA, 8'd255);
		write_reg(REG_CA_ENABLE, 8'hFF);
		write_reg(REG_CONST_ALPHA, 8'd128);
		write_reg(REG_UNUSED, 8'h03);
		send_vertex(make_vertex(32'hFFFF_FFFF, 1'b1));
		send_vertex(make_vertex(32'h1234_5680, 1'b0));
		wait_drained();
		write_reg(REG_CA_ENABLE, 8'hFE);
		write_reg(REG_CONST_ALPHA, 8'd0);
	endtask

	// Receiver holds off long enough for the queue and front pipe to back up.
	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		write_reg(REG_PRIM_MODE, {6'b0, MODE_FAN});
		hold_len = LONG_HOLD;
		send_vertex(rand_vertex(1'b1));
		repeat (23) send_vertex(rand_vertex(1'b0));
		wait_drained();
	endtask

	// One random setting, then well-formed draws with some noise mixed in.
	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
		int sent;
		int len;
		bit noise;
		bit first;
		logic sod;
		logic [1:0] mode;
		tx_idle_pct  = idle_pct;
		rx_stall_pct = stall_pct;
		mode = 2'($urandom_range(3));
		// upper data bits random, the register keeps only its width
		write_reg(REG_PRIM_MODE, {6'($urandom), mode});
		write_reg(REG_MOD_RED, pick_factor());
		write_reg(REG_MOD_GREEN, pick_factor());
		write_reg(REG_MOD_BLUE, pick_factor());
		write_reg(REG_MOD_ALPHA, pick_factor());
		write_reg(REG_CA_ENABLE, 8'($urandom));
		write_reg(REG_CONST_ALPHA, pick_factor());
		sent  = 0;
		first = 1'b1;
		while (sent < n_items) begin
			noise = ($urandom_range(99) < 15);
			if (noise)
				len = $urandom_range(1, 7);
			else begin
				case (mode)
					MODE_LIST: len = $urandom_range(1, 6);
					MODE_QUAD: len = 4 * $urandom_range(1, 3);
					default:   len = $urandom_range(3, 9);
				endcase
			end
			for (int k = 0; k < len; k++) begin
				// now and then the first draw carries on from the previous setting
				if (k == 0)
					sod = !(first && $urandom_range(99) < 25);
				else
					sod = ($urandom_range(99) < 3);
				send_vertex(rand_vertex(sod));
				sent++;
			end
			first = 1'b0;
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------- receiver and checks

	always @(posedge clk) begin
		if (hold_len > 0) begin
			out_ready <= 1'b0;
			hold_len = hold_len - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %h, actual %h", name, exp_val, act_val);
			errors++;
		end
	endfunction

	// Every output request is matched against the oldest predicted vertex.
	always @(posedge clk) begin : check_results
		list_vertex_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_vertices.size() == 0) begin
				$error("output request with no vertex predicted");
				errors++;
			end else begin
				e = expected_vertices.pop_front();
				check_field("out_pos_x", e.vtx.pos_x, out_pos_x);
				check_field("out_pos_y", e.vtx.pos_y, out_pos_y);
				check_field("out_pos_z", e.vtx.pos_z, out_pos_z);
				check_field("out_tex_u", e.vtx.tex_u, out_tex_u);
				check_field("out_tex_v", e.vtx.tex_v, out_tex_v);
				check_field("out_red", 32'(e.vtx.red), 32'(out_red));
				check_field("out_green", 32'(e.vtx.green), 32'(out_green));
				check_field("out_blue", 32'(e.vtx.blue), 32'(out_blue));
				check_field("out_alpha", 32'(e.vtx.alpha), 32'(out_alpha));
				check_field("run_last", 32'(e.last), 32'(run_last));
			end
		end
	end

	// Hang detector: no request taken on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		// register defaults and cleared assembly state
		cur_mode        = MODE_LIST;
		cur_mod_red     = 8'd255;
		cur_mod_green   = 8'd255;
		cur_mod_blue    = 8'd255;
		cur_mod_alpha   = 8'd255;
		cur_ca_en       = 1'b0;
		cur_const_alpha = 8'd255;
		held_count      = 2'd0;
		strip_odd       = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++)
			held_slots[i] = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_list_defaults();
		test_quad_list();
		test_strip_winding();
		test_fan_origin();
		test_mode_switch();
		test_const_alpha_and_masking();
		test_backpressure();

		// idling patterns: none, sender idle, receiver stalling, both a little
		for (int p = 0; p < 2; p++) begin
			test_random_phase(0, 0, 12);
			test_random_phase(67, 0, 12);
			test_random_phase(0, 67, 12);
			test_random_phase(8, 8, 12);
		end

		wait_drained();
		if (errors == 0 && expected_vertices.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
